/* hdl/bitmap_page_allocator_core_assert.svh */
// Assertion macros for the checker file of the page allocator.
`ifndef BITMAP_PAGE_ALLOCATOR_CORE_ASSERT_SVH
`define BITMAP_PAGE_ALLOCATOR_CORE_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define BPA_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define BPA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/bpa_pkg.sv */
// Types, codes and defaults shared by the page allocator modules.
package bpa_pkg;

    localparam int PAGES_DEF     = 64;
    localparam int PROCESSES_DEF = 256;

    localparam int PID_W   = 8;
    localparam int COUNT_W = 7;
    localparam int START_W = 6;

    typedef enum logic [1:0] {
        FIT_FIRST,
        FIT_NEXT,
        FIT_BEST,
        FIT_WORST
    } fit_mode_t;

    localparam fit_mode_t FIT_MODE_RESET = FIT_WORST;

    typedef enum logic {
        OP_LOAD,
        OP_UNLOAD
    } op_t;

    typedef enum logic [1:0] {
        ST_OK,
        ST_LOADED,
        ST_NO_RUN,
        ST_NOT_LOADED
    } status_t;

    typedef struct packed {
        op_t                op;
        logic [PID_W-1:0]   process_id;
        logic [COUNT_W-1:0] page_count;
    } req_t;

    typedef struct packed {
        status_t            status;
        logic [START_W-1:0] start_page;
    } resp_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOKUP,
        S_SCAN,
        S_PLACE,
        S_DONE
    } state_t;

    typedef struct packed {
        logic clear;
        logic step;
    } scan_cmd_t;

    typedef struct packed {
        logic req_valid;
        logic unload;
        logic id_ok;
        logic entry_valid;
        logic count_ok;
        logic scan_last;
        logic found;
        logic out_free;
    } ctrl_stat_t;

    typedef struct packed {
        logic      stall;
        logic      capture;
        scan_cmd_t scan;
        logic      load_commit;
        logic      unload_commit;
        logic      res_we;
        status_t   res_status;
        logic      out_push;
    } ctrl_cmd_t;

endpackage

/* hdl/bpa_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module bpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/bpa_scan.sv */
// Page scan unit: walks the occupancy map one page a cycle and tracks free runs.
module bpa_scan
    import bpa_pkg::*;
#(
    parameter int PAGES = PAGES_DEF,
    localparam int PG_W  = $clog2(PAGES),
    localparam int CNT_W = $clog2(PAGES + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  scan_cmd_t        cmd,
    input  logic [PAGES-1:0] page_map,
    input  fit_mode_t        mode,
    input  logic [CNT_W-1:0] nf_pos,
    input  logic [CNT_W-1:0] k,
    output logic             last,
    output logic             found,
    output logic [PG_W-1:0]  pos
);

    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] ca_reg, ca_next;
    logic [CNT_W-1:0] cb_reg, cb_next;
    logic             fa_reg, fa_next;
    logic             fb_reg, fb_next;
    logic [PG_W-1:0]  pa_reg, pa_next;
    logic [PG_W-1:0]  pb_reg, pb_next;
    logic [CNT_W-1:0] best_reg, best_next;

    logic sentinel;
    logic used_b;
    logic used_a;
    logic take_a;
    logic fb_ok;

    assign sentinel = (idx_reg == CNT_W'(PAGES));
    assign last     = sentinel;
    // past the last page counts as used so the final run closes
    assign used_b   = sentinel || page_map[idx_reg[PG_W-1:0]];
    // next fit: pages below the resume point are out of the upper search
    assign used_a   = used_b || ((mode == FIT_NEXT) && (idx_reg < nf_pos));

    assign take_a = !fa_reg
                 || ((mode == FIT_BEST)  && (ca_reg < best_reg))
                 || ((mode == FIT_WORST) && (ca_reg > best_reg));

    always_comb
    begin
        idx_next  = idx_reg;
        ca_next   = ca_reg;
        cb_next   = cb_reg;
        fa_next   = fa_reg;
        fb_next   = fb_reg;
        pa_next   = pa_reg;
        pb_next   = pb_reg;
        best_next = best_reg;
        if (cmd.clear)
        begin
            idx_next = '0;
            ca_next  = '0;
            cb_next  = '0;
            fa_next  = 1'b0;
            fb_next  = 1'b0;
        end
        else if (cmd.step)
        begin
            idx_next = idx_reg + CNT_W'(1);
            if (used_a)
            begin
                if ((ca_reg >= k) && take_a)
                begin
                    fa_next   = 1'b1;
                    pa_next   = PG_W'(idx_reg - ca_reg);
                    best_next = ca_reg;
                end
                ca_next = '0;
            end
            else
            begin
                ca_next = ca_reg + CNT_W'(1);
            end
            if (used_b)
            begin
                if ((cb_reg >= k) && !fb_reg)
                begin
                    fb_next = 1'b1;
                    pb_next = PG_W'(idx_reg - cb_reg);
                end
                cb_next = '0;
            end
            else
            begin
                cb_next = cb_reg + CNT_W'(1);
            end
        end
    end

    // wrapped next-fit run must end at or before the resume point
    assign fb_ok = fb_reg
        && (((CNT_W+1)'(pb_reg) + (CNT_W+1)'(k)) <= (CNT_W+1)'(nf_pos));

    assign found = fa_reg || ((mode == FIT_NEXT) && fb_ok);
    assign pos   = fa_reg ? pa_reg : pb_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
            ca_reg  <= '0;
            cb_reg  <= '0;
            fa_reg  <= 1'b0;
            fb_reg  <= 1'b0;
        end
        else
        begin
            idx_reg <= idx_next;
            ca_reg  <= ca_next;
            cb_reg  <= cb_next;
            fa_reg  <= fa_next;
            fb_reg  <= fb_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pa_reg   <= pa_next;
        pb_reg   <= pb_next;
        best_reg <= best_next;
    end

endmodule

/* hdl/bpa_ctrl.sv */
// Request sequencer: lookup, scan, placement and result hand-off.
module bpa_ctrl
    import bpa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  ctrl_stat_t stat,
    output ctrl_cmd_t  cmd
);

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (stat.req_valid)
                begin
                    state_next = S_LOOKUP;
                end
            end
            S_LOOKUP:
            begin
                if (!stat.unload && stat.id_ok && !stat.entry_valid && stat.count_ok)
                begin
                    state_next = S_SCAN;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_SCAN:
            begin
                if (stat.scan_last)
                begin
                    state_next = S_PLACE;
                end
            end
            S_PLACE:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        cmd.stall      = 1'b1;
        cmd.res_status = ST_OK;
        case (state_reg)
            S_IDLE:
            begin
                cmd.stall   = 1'b0;
                cmd.capture = stat.req_valid;
            end
            S_LOOKUP:
            begin
                cmd.scan.clear = 1'b1;
                if (stat.unload)
                begin
                    cmd.res_we = 1'b1;
                    if (stat.id_ok && stat.entry_valid)
                    begin
                        cmd.unload_commit = 1'b1;
                        cmd.res_status    = ST_OK;
                    end
                    else
                    begin
                        cmd.res_status = ST_NOT_LOADED;
                    end
                end
                else if (!stat.id_ok)
                begin
                    cmd.res_we     = 1'b1;
                    cmd.res_status = ST_NO_RUN;
                end
                else if (stat.entry_valid)
                begin
                    cmd.res_we     = 1'b1;
                    cmd.res_status = ST_LOADED;
                end
                else if (!stat.count_ok)
                begin
                    cmd.res_we     = 1'b1;
                    cmd.res_status = ST_NO_RUN;
                end
            end
            S_SCAN:
            begin
                cmd.scan.step = 1'b1;
            end
            S_PLACE:
            begin
                cmd.res_we = 1'b1;
                if (stat.found)
                begin
                    cmd.load_commit = 1'b1;
                    cmd.res_status  = ST_OK;
                end
                else
                begin
                    cmd.res_status = ST_NO_RUN;
                end
            end
            S_DONE:
            begin
                cmd.out_push = stat.out_free;
            end
            default:
            begin
                cmd.stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* hdl/bitmap_page_allocator_core.sv */
// Top level of the bitmap page allocator: state, process table and result register.
//
//  channel | direction | handshake                      | payload
//  --------+-----------+--------------------------------+---------------------------
//  req     | in        | req_valid / req_stall          | op, process_id, page_count
//  resp    | out       | resp_valid / resp_stall        | status, start_page
//  cfg     | in        | cfg_we (single register)       | cfg_wdata -> fit_mode
//
// A load that reaches the search goes from lookup through PAGES + 1 steps of the page
// scan unit, one page per cycle, then placement and hand-off before the idle state
// takes the next request; every other request goes from lookup straight to hand-off.
// The process table is read through its registered RAM port while the request
// transfers, so that its entry is ready in the lookup state.
// Reset clears the occupancy map, the per-entry valid bits and the resume point and
// sets the mode to worst fit at once; there is no clearing pass.
// A stalled result stays in the output register while the next request is taken;
// hand-off of the following result waits until that register frees.
module bitmap_page_allocator_core
    import bpa_pkg::*;
#(
    parameter int PAGES     = PAGES_DEF,
    parameter int PROCESSES = PROCESSES_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_stall,
    input  req_t       req,
    output logic       resp_valid,
    input  logic       resp_stall,
    output resp_t      resp,
    input  logic       cfg_we,
    input  logic [1:0] cfg_wdata
);

    localparam int PG_W  = $clog2(PAGES);
    localparam int CNT_W = $clog2(PAGES + 1);
    localparam int IDX_W = (PROCESSES > 1) ? $clog2(PROCESSES) : 1;
    localparam int ENT_W = PG_W + CNT_W;

    ctrl_stat_t stat;
    ctrl_cmd_t  cmd;

    req_t             req_reg, req_next;
    fit_mode_t        fit_mode_reg, fit_mode_next;
    logic [PAGES-1:0] page_map_reg, page_map_next;
    logic [PROCESSES-1:0] valid_reg, valid_next;
    logic [CNT_W-1:0] nf_reg, nf_next;
    resp_t            res_reg, res_next;
    resp_t            resp_reg, resp_next;
    logic             resp_valid_reg, resp_valid_next;

    logic [IDX_W-1:0] id_idx;
    logic [IDX_W-1:0] raddr;
    logic [ENT_W-1:0] ent_rdata;
    logic [ENT_W-1:0] ent_wdata;
    logic [PG_W-1:0]  ent_start;
    logic [CNT_W-1:0] ent_count;
    logic [CNT_W-1:0] k;

    logic             scan_last;
    logic             scan_found;
    logic [PG_W-1:0]  scan_pos;

    logic [PG_W-1:0]  run_start;
    logic [CNT_W-1:0] run_len;
    logic [PAGES-1:0] run_mask;

    // Hold the request for the whole search.
    assign id_idx = IDX_W'(req_reg.process_id);
    assign k      = CNT_W'(req_reg.page_count);

    always_comb
    begin
        req_next = req_reg;
        if (cmd.capture)
        begin
            req_next = req;
        end
    end

    // Status fed to the sequencer.
    always_comb
    begin
        stat.req_valid   = req_valid;
        stat.unload      = (req_reg.op == OP_UNLOAD);
        stat.id_ok       = (int'(req_reg.process_id) < PROCESSES);
        stat.entry_valid = valid_reg[id_idx];
        stat.count_ok    = (req_reg.page_count != '0)
                        && (int'(req_reg.page_count) <= PAGES);
        stat.scan_last   = scan_last;
        stat.found       = scan_found;
        stat.out_free    = !resp_valid_reg || !resp_stall;
    end

    bpa_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .cmd   (cmd)
    );

    // Process table: start page and count per entry, valid bits kept in flops.
    // Read the entry of the incoming request while it transfers.
    assign raddr     = cmd.capture ? IDX_W'(req.process_id) : id_idx;
    assign ent_wdata = {scan_pos, k};
    assign ent_start = ent_rdata[ENT_W-1:CNT_W];
    assign ent_count = ent_rdata[CNT_W-1:0];

    bpa_ram #(
        .WIDTH (ENT_W),
        .DEPTH (PROCESSES)
    ) u_table (
        .clk   (clk),
        .we    (cmd.load_commit),
        .waddr (id_idx),
        .wdata (ent_wdata),
        .raddr (raddr),
        .rdata (ent_rdata)
    );

    bpa_scan #(
        .PAGES (PAGES)
    ) u_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd.scan),
        .page_map (page_map_reg),
        .mode     (fit_mode_reg),
        .nf_pos   (nf_reg),
        .k        (k),
        .last     (scan_last),
        .found    (scan_found),
        .pos      (scan_pos)
    );

    // One run mask serves both placement and release; each page compares on its own.
    assign run_start = cmd.load_commit ? scan_pos : ent_start;
    assign run_len   = cmd.load_commit ? k : ent_count;

    always_comb
    begin
        for (int j = 0; j < PAGES; j++)
        begin
            run_mask[j] = (j >= int'(run_start)) && (j < int'(run_start) + int'(run_len));
        end
    end

    always_comb
    begin
        page_map_next = page_map_reg;
        valid_next    = valid_reg;
        nf_next       = nf_reg;
        if (cmd.load_commit)
        begin
            page_map_next      = page_map_reg | run_mask;
            valid_next[id_idx] = 1'b1;
            // only next fit advances the resume point
            if (fit_mode_reg == FIT_NEXT)
            begin
                nf_next = CNT_W'((CNT_W+1)'(scan_pos) + (CNT_W+1)'(k));
            end
        end
        else if (cmd.unload_commit)
        begin
            page_map_next      = page_map_reg & ~run_mask;
            valid_next[id_idx] = 1'b0;
        end
    end

    always_comb
    begin
        fit_mode_next = fit_mode_reg;
        if (cfg_we)
        begin
            fit_mode_next = fit_mode_t'(cfg_wdata);
        end
    end

    // Result: start page is zero except on a successful load.
    always_comb
    begin
        res_next = res_reg;
        if (cmd.res_we)
        begin
            res_next.status     = cmd.res_status;
            res_next.start_page = cmd.load_commit ? START_W'(scan_pos) : '0;
        end
    end

    // Output register: advance on push, drop valid once the transfer completes.
    always_comb
    begin
        resp_next       = resp_reg;
        resp_valid_next = resp_valid_reg && resp_stall;
        if (cmd.out_push)
        begin
            resp_next       = res_reg;
            resp_valid_next = 1'b1;
        end
    end

    assign req_stall  = cmd.stall;
    assign resp_valid = resp_valid_reg;
    assign resp       = resp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fit_mode_reg   <= FIT_MODE_RESET;
            page_map_reg   <= '0;
            valid_reg      <= '0;
            nf_reg         <= '0;
            resp_valid_reg <= 1'b0;
        end
        else
        begin
            fit_mode_reg   <= fit_mode_next;
            page_map_reg   <= page_map_next;
            valid_reg      <= valid_next;
            nf_reg         <= nf_next;
            resp_valid_reg <= resp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg  <= req_next;
        res_reg  <= res_next;
        resp_reg <= resp_next;
    end

endmodule

/* hdl/bpa_chk.sv */
// Port-level checker for the page allocator, bound to the top level.
`include "bitmap_page_allocator_core_assert.svh"

module bpa_chk
    import bpa_pkg::*;
(
    input logic  clk,
    input logic  rst_n,
    input logic  req_valid,
    input logic  req_stall,
    input logic  resp_valid,
    input logic  resp_stall,
    input resp_t resp
);

    // a stalled result holds
    `BPA_ASSERT_NEXT(a_resp_hold, clk, rst_n, resp_valid && resp_stall, resp_valid && $stable(resp), "stalled result changed")

    // one request at a time: a transfer closes the request channel next cycle
    `BPA_ASSERT_NEXT(a_req_busy, clk, rst_n, req_valid && !req_stall, req_stall, "request taken while busy")

    // a new result only appears while a request is in progress
    `BPA_ASSERT_SAME(a_resp_origin, clk, rst_n, $rose(resp_valid), $past(req_stall), "result without request")

    // only a successful load carries a start page
    `BPA_ASSERT_SAME(a_start_zero, clk, rst_n, resp_valid && (resp.status != ST_OK), resp.start_page == '0, "start page on failed result")

endmodule

bind bitmap_page_allocator_core bpa_chk u_bpa_chk (.*);
